// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the access-rights cache modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_SAME(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lac_pkg.sv =====
// ----------------------------------------------------------------------------
// lac_pkg
// Shared constants, opcodes and structs of the access-rights cache.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int USER_BITS = 16;

    // Request kinds on i_req_type
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_INVAL  = 2'd2;
    localparam logic [1:0] REQ_FREE   = 2'd3;

    // Update broadcast to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HIT,
        OP_EXPIRE,
        OP_ADD_HIT,
        OP_ADD_MISS,
        OP_INVAL,
        OP_FREE
    } t_op;

    typedef struct packed {
        logic                 valid;
        t_op                  op;
        logic [IDX_W-1:0]     sel_rank;
        logic [31:0]          object_id;
        logic [USER_BITS-1:0] user_id;
        logic [31:0]          rights;
        logic [31:0]          lifetime;
    } t_cmd;

    // Cell status; rank, rights and lifetime are masked by the cell's match flag so they can be OR-reduced
    typedef struct packed {
        logic             match;
        logic             victim;
        logic [IDX_W-1:0] rank;
        logic [31:0]      rights;
        logic [31:0]      lifetime;
    } t_stat;

endpackage

// ===== rtl/lru_access_rights_cache_top.sv =====
// Steps: the request is registered, the cells register the tag compare (S_CMP), then
// the matching entry is OR-gathered across all cells and the recency update is broadcast
// (S_UPD), after which o_done is registered. busy is high only for the compare cycle, so a
// new request can be taken while the previous one is in its update step.
// Reset (synchronous, active low) frees all entries and sets rank to entry index.
// Results are shown for one cycle on o_done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// lru_access_rights_cache_top
// Access-rights cache of (object, user) pairs with expiry and global LRU order,
// built as a row of entry cells fed by a two-step sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_access_rights_cache_top import lac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_object_id,
    input  logic [15:0] i_user_id,
    input  logic [31:0] i_rights_in,
    input  logic [31:0] i_lifetime,
    input  logic [31:0] i_current_time,
    output logic        o_done,
    output logic        o_hit,
    output logic [31:0] o_rights_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state               r_state;
    logic [1:0]           r_req;
    logic [31:0]          r_object;
    logic [USER_BITS-1:0] r_user;
    logic [31:0]          r_rights;
    logic [31:0]          r_life;
    logic [31:0]          r_now;
    logic                 r_done;
    logic                 r_hit;
    logic [31:0]          r_rout;

    t_stat                w_stat [ENTRIES];
    logic [ENTRIES-1:0]   w_match;
    logic [ENTRIES-1:0]   w_victim;
    logic [IDX_W-1:0]     w_sel_rank;
    logic [31:0]          w_sel_rights;
    logic [31:0]          w_sel_life;
    logic                 w_any;
    logic                 w_expired;
    logic                 w_accept;
    t_cmd                 w_cmd;
    logic                 w_hit;
    logic [31:0]          w_rout;

    assign busy     = (r_state == S_CMP);
    assign w_accept = start && !busy;

    // Gather the matching entry from all cells
    always_comb begin
        w_sel_rank   = '0;
        w_sel_rights = '0;
        w_sel_life   = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_match[k]   = w_stat[k].match;
            w_victim[k]  = w_stat[k].victim;
            w_sel_rank   = w_sel_rank   | w_stat[k].rank;
            w_sel_rights = w_sel_rights | w_stat[k].rights;
            w_sel_life   = w_sel_life   | w_stat[k].lifetime;
        end
        w_any     = |w_match;
        w_expired = (w_sel_life != '0) && (w_sel_life <= r_now);
    end

    // Decide the update and the result
    always_comb begin
        w_cmd.valid     = (r_state == S_UPD);
        w_cmd.op        = OP_NONE;
        w_cmd.sel_rank  = w_sel_rank;
        w_cmd.object_id = r_object;
        w_cmd.user_id   = r_user;
        w_cmd.rights    = r_rights;
        w_cmd.lifetime  = (w_sel_life < r_life) ? r_life : w_sel_life;
        w_hit           = 1'b0;
        w_rout          = '0;
        case (r_req)
            REQ_LOOKUP: begin
                if (w_any && w_expired) begin
                    w_cmd.op = OP_EXPIRE;
                end else if (w_any) begin
                    w_cmd.op = OP_HIT;
                    w_hit    = 1'b1;
                    w_rout   = w_sel_rights;
                end
            end
            REQ_ADD: begin
                if (w_any) begin
                    w_cmd.op = OP_ADD_HIT;
                    w_hit    = 1'b1;
                end else begin
                    w_cmd.op       = OP_ADD_MISS;
                    w_cmd.sel_rank = '0;
                    w_cmd.lifetime = r_life;
                end
            end
            REQ_INVAL: begin
                w_cmd.op = OP_INVAL;
                w_hit    = w_any;
            end
            REQ_FREE: begin
                w_cmd.op = OP_FREE;
            end
            default: begin
            end
        endcase
    end

    // Row of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lac_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (IDX_W'(g)),
            .i_cmp       (r_state == S_CMP),
            .i_object_id (r_object),
            .i_user_id   (r_user),
            .i_cmd       (w_cmd),
            .o_stat      (w_stat[g])
        );
    end

    // Sequence compare and update, register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
            r_rout  <= '0;
        end else begin
            r_done <= (r_state == S_UPD);
            if (r_state == S_UPD) begin
                r_hit  <= w_hit;
                r_rout <= w_rout;
            end
            case (r_state)
                S_IDLE:  r_state <= w_accept ? S_CMP : S_IDLE;
                S_CMP:   r_state <= S_UPD;
                S_UPD:   r_state <= w_accept ? S_CMP : S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture the request item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= i_req_type;
            r_object <= i_object_id;
            r_user   <= i_user_id[USER_BITS-1:0];
            r_rights <= i_rights_in;
            r_life   <= i_lifetime;
            r_now    <= i_current_time;
        end
    end

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_rights_out = r_rout;

    `AST_NEXT(a_busy_one_cycle, i_clk, i_rst_n, busy, !busy && !o_done)
    `AST_NEXT(a_done_after_upd, i_clk, i_rst_n, r_state == S_UPD, o_done)
    `AST_SAME(a_match_unique, i_clk, i_rst_n, r_state == S_UPD, $onehot0(w_match))
    `AST_SAME(a_victim_unique, i_clk, i_rst_n, r_state == S_UPD, $onehot(w_victim))
    `AST_SAME(a_miss_no_rights, i_clk, i_rst_n, o_done && !o_hit, o_rights_out == '0)

endmodule

// ===== rtl/lac_cell.sv =====
// ----------------------------------------------------------------------------
// lac_cell
// One cache entry: tag, rights, lifetime and recency rank, with its compare
// stage and the rank update shared by all cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lac_cell import lac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IDX_W-1:0]     i_index,
    input  logic                 i_cmp,
    input  logic [31:0]          i_object_id,
    input  logic [USER_BITS-1:0] i_user_id,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    logic                 r_in_use;
    logic [31:0]          r_object;
    logic [USER_BITS-1:0] r_user;
    logic [31:0]          r_rights;
    logic [31:0]          r_life;
    logic [IDX_W-1:0]     r_rank;
    logic                 r_match;
    logic                 r_obj_eq;
    logic                 r_victim;

    logic                 n_in_use;
    logic [31:0]          n_rights;
    logic [31:0]          n_life;
    logic [IDX_W-1:0]     n_rank;
    logic                 w_sel;
    logic                 w_mru;
    logic                 w_load;

    // Pick this cell's role in the broadcast update
    always_comb begin
        w_mru  = (i_cmd.op == OP_HIT) || (i_cmd.op == OP_ADD_HIT) ||
                 (i_cmd.op == OP_ADD_MISS);
        w_sel  = (i_cmd.op == OP_ADD_MISS) ? r_victim : r_match;
        w_load = 1'b0;
        n_in_use = r_in_use;
        n_rights = r_rights;
        n_life   = r_life;
        n_rank   = r_rank;
        if (i_cmd.valid) begin
            // Move within the recency order
            if (w_mru) begin
                if (w_sel) begin
                    n_rank = IDX_W'(ENTRIES - 1);
                end else if (r_rank > i_cmd.sel_rank) begin
                    n_rank = r_rank - 1'b1;
                end
            end else if (i_cmd.op == OP_EXPIRE) begin
                if (w_sel) begin
                    n_rank = '0;
                end else if (r_rank < i_cmd.sel_rank) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            // Entry contents
            case (i_cmd.op)
                OP_EXPIRE: begin
                    if (w_sel) begin
                        n_in_use = 1'b0;
                        n_rights = '0;
                        n_life   = '0;
                    end
                end
                OP_ADD_HIT: begin
                    if (w_sel) begin
                        n_rights = i_cmd.rights;
                        n_life   = i_cmd.lifetime;
                    end
                end
                OP_ADD_MISS: begin
                    if (w_sel) begin
                        n_in_use = 1'b1;
                        n_rights = i_cmd.rights;
                        n_life   = i_cmd.lifetime;
                        w_load   = 1'b1;
                    end
                end
                OP_INVAL: begin
                    if (w_sel) begin
                        n_in_use = 1'b0;
                    end
                end
                OP_FREE: begin
                    if (r_obj_eq) begin
                        n_in_use = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold control state, rank and contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= 1'b0;
            r_rights <= '0;
            r_life   <= '0;
            r_rank   <= i_index;
            r_match  <= 1'b0;
            r_obj_eq <= 1'b0;
            r_victim <= 1'b0;
        end else begin
            r_in_use <= n_in_use;
            r_rights <= n_rights;
            r_life   <= n_life;
            r_rank   <= n_rank;
            if (i_cmp) begin
                r_obj_eq <= r_in_use && (r_object == i_object_id);
                r_match  <= r_in_use && (r_object == i_object_id) && (r_user == i_user_id);
                r_victim <= (r_rank == '0);
            end
        end
    end

    // Load the tag on reclaim
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_object <= i_cmd.object_id;
            r_user   <= i_cmd.user_id;
        end
    end

    // Report masked by match so the top can OR all cells together
    always_comb begin
        o_stat.match    = r_match;
        o_stat.victim   = r_victim;
        o_stat.rank     = r_match ? r_rank   : '0;
        o_stat.rights   = r_match ? r_rights : '0;
        o_stat.lifetime = r_match ? r_life   : '0;
    end

    `AST_SAME(a_match_in_use, i_clk, i_rst_n, r_match && i_cmd.valid, r_in_use)
    `AST_SAME(a_match_obj, i_clk, i_rst_n, r_match, r_obj_eq)
    `AST_NEXT(a_load_in_use, i_clk, i_rst_n, w_load, r_in_use)

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the access-rights cache. A queue of requests feeds a
// clocked driver. The driver runs an in-bench model of the entry pool (expiry,
// global recency order, reclaim of the least recent entry) on every accepted
// item and queues the expected hit flag and rights. A clocked monitor checks
// each o_done strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top import lac_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               IDLE_LIMIT = 2000;
    localparam int               RANDOM_ITEMS = 1400;
    localparam logic [15:0]      USER_MASK = 16'((64'd1 << USER_BITS) - 64'd1);

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] obj;
        logic [15:0] usr;
        logic [31:0] rights;
        logic [31:0] life;
        logic [31:0] now;
        logic [7:0]  gap;
        logic        drain;
    } access_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] rights;
    } access_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        o_done;
    logic        o_hit;
    logic [31:0] o_rights_out;

    access_req_t    cur_req = '0;
    access_req_t    request_queue[$];
    access_result_t rights_due[$];
    logic [7:0]     gap_left = '0;
    int             mismatch_count = 0;
    int             idle_cycles = 0;

    // Shadow copy of the entry pool
    logic                 pool_in_use[ENTRIES];
    logic [31:0]          pool_object[ENTRIES];
    logic [15:0]          pool_user[ENTRIES];
    logic [31:0]          pool_rights[ENTRIES];
    logic [31:0]          pool_lifetime[ENTRIES];
    logic [IDX_W-1:0]     pool_rank[ENTRIES];

    // Working sets that make hits, reclaims and expiry likely
    logic [31:0] obj_set[16];
    logic [15:0] usr_set[8];
    logic [31:0] clock_now;

    lru_access_rights_cache_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (cur_req.req),
        .i_object_id    (cur_req.obj),
        .i_user_id      (cur_req.usr),
        .i_rights_in    (cur_req.rights),
        .i_lifetime     (cur_req.life),
        .i_current_time (cur_req.now),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_rights_out   (o_rights_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Move an entry to the most recent end of the order
    function automatic void promote(int e);
        logic [IDX_W-1:0] r;
        r = pool_rank[e];
        for (int i = 0; i < ENTRIES; i++)
            if (pool_rank[i] > r) pool_rank[i] = pool_rank[i] - 1'b1;
        pool_rank[e] = IDX_W'(ENTRIES - 1);
    endfunction

    // Move an entry to the least recent end of the order
    function automatic void demote(int e);
        logic [IDX_W-1:0] r;
        r = pool_rank[e];
        for (int i = 0; i < ENTRIES; i++)
            if (pool_rank[i] < r) pool_rank[i] = pool_rank[i] + 1'b1;
        pool_rank[e] = '0;
    endfunction

    function automatic int find_entry(logic [31:0] obj, logic [15:0] usr);
        for (int i = 0; i < ENTRIES; i++)
            if (pool_in_use[i] && pool_object[i] == obj && pool_user[i] == usr)
                return i;
        return -1;
    endfunction

    // Apply one request to the shadow pool and queue its expected result
    function automatic void cache_access(access_req_t r);
        access_result_t res;
        logic [15:0]    usr;
        int             e;
        res = '0;
        usr = r.usr & USER_MASK;
        e = find_entry(r.obj, usr);
        case (r.req)
            REQ_LOOKUP: begin
                if (e >= 0) begin
                    if (pool_lifetime[e] != 0 && pool_lifetime[e] <= r.now) begin
                        pool_in_use[e] = 1'b0;
                        pool_rights[e] = '0;
                        pool_lifetime[e] = '0;
                        demote(e);
                    end else begin
                        res.hit = 1'b1;
                        res.rights = pool_rights[e];
                        promote(e);
                    end
                end
            end
            REQ_ADD: begin
                if (e >= 0) begin
                    res.hit = 1'b1;
                    pool_rights[e] = r.rights;
                    if (pool_lifetime[e] < r.life) pool_lifetime[e] = r.life;
                    promote(e);
                end else begin
                    e = 0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (pool_rank[i] == 0) e = i;
                    pool_in_use[e] = 1'b1;
                    pool_object[e] = r.obj;
                    pool_user[e] = usr;
                    pool_rights[e] = r.rights;
                    pool_lifetime[e] = r.life;
                    promote(e);
                end
            end
            REQ_INVAL: begin
                if (e >= 0) begin
                    res.hit = 1'b1;
                    pool_in_use[e] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (pool_in_use[i] && pool_object[i] == r.obj) pool_in_use[i] = 1'b0;
            end
        endcase
        rights_due.push_back(res);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic logic [7:0] pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 8'd0;
        if (p < 85) return 8'($urandom_range(1, 3));
        if (p < 95) return 8'($urandom_range(4, 8));
        return 8'($urandom_range(15, 40));
    endfunction

    task automatic add_req(logic [1:0] req, logic [31:0] obj, logic [15:0] usr,
                           logic [31:0] rights, logic [31:0] life, logic [31:0] now,
                           logic [7:0] gap, logic drain);
        access_req_t r;
        r = '{req: req, obj: obj, usr: usr, rights: rights, life: life,
              now: now, gap: gap, drain: drain};
        request_queue.push_back(r);
    endtask

    // Driver: hold each item until taken, then advance after its gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= '0;
        end else if (start && !busy) begin
            cache_access(cur_req);
            if (request_queue.size() > 0 && request_queue[0].gap == 0
                    && !request_queue[0].drain) begin
                cur_req <= request_queue.pop_front();
            end else begin
                start <= 1'b0;
                if (request_queue.size() > 0) gap_left <= request_queue[0].gap;
            end
        end else if (!start && request_queue.size() > 0) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1'b1;
            end else if (!request_queue[0].drain || rights_due.size() == 0) begin
                cur_req <= request_queue.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        access_result_t want;
        if (i_rst_n && o_done) begin
            if (rights_due.size() == 0) begin
                $error("unexpected result: hit=%0b rights_out=%h", o_hit, o_rights_out);
                mismatch_count++;
            end else begin
                want = rights_due.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, o_hit);
                    mismatch_count++;
                end
                if (o_rights_out !== want.rights) begin
                    $error("rights_out: expected %h, got %h", want.rights, o_rights_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: stop if neither side moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] a_obj;
        logic [31:0] b_obj;
        logic [31:0] c_obj;
        logic [1:0]  req;
        logic [31:0] life;
        logic [31:0] now;
        logic [7:0]  gap;
        int          p;

        for (int i = 0; i < ENTRIES; i++) begin
            pool_in_use[i] = 1'b0;
            pool_object[i] = '0;
            pool_user[i] = '0;
            pool_rights[i] = '0;
            pool_lifetime[i] = '0;
            pool_rank[i] = IDX_W'(i);
        end

        // Directed: empty pool, lifetime extremes, expiry boundary, update on a
        // stale entry, invalidate hit and miss, free of present and absent objects
        a_obj = 32'h0000_0000;
        b_obj = 32'hFFFF_FFFF;
        c_obj = 32'h1234_5678;
        add_req(REQ_LOOKUP, a_obj, 16'h0000, '0, '0, 32'd0, 8'd0, 1'b0);
        add_req(REQ_ADD, a_obj, 16'h0000, 32'hFFFF_FFFF, 32'd0, '0, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, a_obj, 16'h0000, '0, '0, 32'hFFFF_FFFF, pick_gap(), 1'b0);
        add_req(REQ_ADD, a_obj, 16'h0000, 32'h0000_00A5, 32'd100, '0, pick_gap(), 1'b0);
        add_req(REQ_ADD, a_obj, 16'h0000, 32'h0000_005A, 32'd50, '0, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, a_obj, 16'h0000, '0, '0, 32'd99, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, a_obj, 16'h0000, '0, '0, 32'd100, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, a_obj, 16'h0000, '0, '0, 32'd0, pick_gap(), 1'b0);
        add_req(REQ_ADD, b_obj, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, '0, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, b_obj, 16'hFFFF, '0, '0, 32'hFFFF_FFFE, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, b_obj, 16'hFFFF, '0, '0, 32'hFFFF_FFFF, pick_gap(), 1'b0);
        add_req(REQ_ADD, c_obj, 16'h0001, 32'd1, 32'd10, 32'd500, pick_gap(), 1'b0);
        add_req(REQ_ADD, c_obj, 16'h0001, 32'd2, 32'd20, 32'd500, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, c_obj, 16'h0001, '0, '0, 32'd19, pick_gap(), 1'b0);
        add_req(REQ_INVAL, c_obj, 16'h0001, '0, '0, '0, pick_gap(), 1'b0);
        add_req(REQ_INVAL, c_obj, 16'h0001, '0, '0, '0, pick_gap(), 1'b0);
        add_req(REQ_ADD, c_obj, 16'h0002, 32'd3, 32'd0, '0, pick_gap(), 1'b0);
        add_req(REQ_ADD, c_obj, 16'h0003, 32'd4, 32'd0, '0, pick_gap(), 1'b0);
        add_req(REQ_ADD, b_obj, 16'h0002, 32'd5, 32'd0, '0, pick_gap(), 1'b0);
        add_req(REQ_FREE, c_obj, 16'h0002, '0, '0, '0, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, c_obj, 16'h0002, '0, '0, 32'd0, pick_gap(), 1'b0);
        add_req(REQ_LOOKUP, b_obj, 16'h0002, '0, '0, 32'hFFFF_FFFF, pick_gap(), 1'b0);
        add_req(REQ_FREE, 32'hDEAD_BEEF, 16'h0000, '0, '0, '0, pick_gap(), 1'b0);
        add_req(REQ_INVAL, b_obj, 16'hFFFF, '0, '0, '0, pick_gap(), 1'b0);

        // Random: working sets wider than the pool so reclaims happen
        for (int i = 0; i < 16; i++) obj_set[i] = $urandom();
        for (int i = 0; i < 8; i++) usr_set[i] = 16'($urandom());
        clock_now = $urandom_range(1000, 1_000_000);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            access_req_t r;
            clock_now = clock_now + 32'($urandom_range(0, 3));
            // Every 100 items, run a stretch back to back
            gap = (i % 100 < 25) ? 8'd0 : pick_gap();
            p = $urandom_range(0, 99);
            if (p < 6) begin
                // Noise: every request field but gap and drain from its full range
                r = '{req: 2'($urandom()), obj: $urandom(), usr: 16'($urandom()),
                      rights: $urandom(), life: $urandom(), now: $urandom(),
                      gap: gap, drain: (i == 0) || (i == RANDOM_ITEMS / 2)};
                request_queue.push_back(r);
            end else begin
                if (p < 45) req = REQ_LOOKUP;
                else if (p < 80) req = REQ_ADD;
                else if (p < 93) req = REQ_INVAL;
                else req = REQ_FREE;
                p = $urandom_range(0, 9);
                if (p < 2) life = '0;
                else if (p < 8) life = clock_now + 32'($urandom_range(1, 150));
                else if (p < 9) life = clock_now - 32'($urandom_range(0, 20));
                else life = $urandom();
                now = ($urandom_range(0, 9) == 0) ? $urandom() : clock_now;
                add_req(req, obj_set[$urandom_range(0, 15)], usr_set[$urandom_range(0, 7)],
                        $urandom(), life, now, gap, (i == 0) || (i == RANDOM_ITEMS / 2));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then allow the pipeline to settle
        @(posedge i_clk);
        while (request_queue.size() > 0 || start || rights_due.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lac_pkg.sv
rtl/lac_cell.sv
rtl/lru_access_rights_cache_top.sv
bench/tb_top.sv
